>>> sv/cela_pkg.sv
// shared types, constants and log table builder for the cross-entropy loss accumulator
`default_nettype none
package cela_pkg;

    localparam int unsigned IDX_W_MAX = 12;
    localparam logic [15:0] LN2_Q16 = 16'd45426;
    localparam logic [15:0] ONE_Q15 = 16'd32768;

    typedef struct packed {
        logic [15:0] prediction;
        logic [15:0] truth;
        logic        last;
    } t_in;

    typedef struct packed {
        logic [31:0] loss;
        logic        bad_prediction;
    } t_out;

    typedef struct packed {
        logic [3:0]           shift;
        logic [IDX_W_MAX-1:0] idx;
        logic [15:0]          truth;
        logic                 bad;
        logic                 last;
    } t_cls;

    // restoring long division, used only while building the table
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            r = (r << 1) | ((num >> b) & 64'd1);
            if (r >= den) begin
                r = r - den;
                q = q | (64'd1 << b);
            end
        end
        return q;
    endfunction

    // ln(1 + index / 2^tab_bits) in q16.16, atanh series in q2.30
    function automatic logic [31:0] ln_entry(input int tab_bits, input int index);
        longint unsigned den;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned k;
        den  = 2 * (longint'(1) << tab_bits) + longint'(index);
        z    = div_u64(longint'(index) << 30, den);
        z2   = (z * z) >> 30;
        term = z;
        acc  = 0;
        for (k = 0; term != 0 && k < 64; k++) begin
            acc  = acc + div_u64(term, 2 * k + 1);
            term = (term * z2) >> 30;
        end
        return 32'((2 * acc + 64'd8192) >> 14);
    endfunction

endpackage
`default_nettype wire

>>> sv/cela_front.sv
// front end: accepts transactions and classifies them into shift and table index
`default_nettype none
module cela_front #(
    parameter int LOG_TABLE_BITS = 8
) (
    input  wire logic            i_valid,
    input  wire cela_pkg::t_in   i_data,
    input  wire logic            i_full,
    output logic                 o_stall,
    output logic                 o_push,
    output cela_pkg::t_cls       o_cls
);
    import cela_pkg::*;

    logic [15:0] w_p;
    logic [3:0]  w_lead;
    logic [3:0]  w_shift;
    logic [15:0] w_norm;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        if (i_data.prediction == 16'd0) begin
            w_p = 16'd1;
        end else if (i_data.prediction > ONE_Q15) begin
            w_p = ONE_Q15;
        end else begin
            w_p = i_data.prediction;
        end
        w_lead = 4'd0;
        for (int b = 0; b < 16; b++) begin
            if (w_p[b]) begin
                w_lead = 4'(b);
            end
        end
        w_shift = 4'd15 - w_lead;
        w_norm  = w_p << w_shift;
    end

    always_comb begin
        o_cls       = '0;
        o_cls.shift = w_shift;
        o_cls.idx[LOG_TABLE_BITS-1:0] = w_norm[14 -: LOG_TABLE_BITS];
        o_cls.truth = i_data.truth;
        o_cls.bad   = (i_data.prediction == 16'd0) && (i_data.truth != 16'd0);
        o_cls.last  = i_data.last;
    end

endmodule
`default_nettype wire

>>> sv/cela_queue.sv
// four-entry queue of classified transactions between front and back
`default_nettype none
module cela_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire cela_pkg::t_cls  i_cls,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output cela_pkg::t_cls       o_cls
);
    import cela_pkg::*;

    localparam int Depth = 4;

    t_cls        r_mem [Depth];
    logic [1:0]  r_wptr, n_wptr;
    logic [1:0]  r_rptr, n_rptr;
    logic [2:0]  r_count, n_count;
    logic        w_do_push;
    logic        w_do_pop;

    assign o_full    = (r_count == 3'(Depth));
    assign o_empty   = (r_count == 3'd0);
    assign o_cls     = r_mem[r_rptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = w_do_push ? r_wptr + 2'd1 : r_wptr;
        n_rptr  = w_do_pop ? r_rptr + 2'd1 : r_rptr;
        n_count = r_count + 3'(w_do_push) - 3'(w_do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_cls;
        end
    end

endmodule
`default_nettype wire

>>> sv/cela_back.sv
// back end: table lookup, multiply, saturating accumulate and result register
`default_nettype none
module cela_back #(
    parameter int LOG_TABLE_BITS = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_empty,
    input  wire cela_pkg::t_cls  i_cls,
    output logic                 o_pop,
    output logic                 o_valid,
    output cela_pkg::t_out       o_data,
    input  wire logic            i_stall
);
    import cela_pkg::*;

    localparam int TabSize = 1 << LOG_TABLE_BITS;

    logic [15:0] w_rom [TabSize];

    for (genvar gi = 0; gi < TabSize; gi++) begin : g_rom
        localparam logic [15:0] Entry = 16'(ln_entry(LOG_TABLE_BITS, gi));
        assign w_rom[gi] = Entry;
    end

    logic        w_en;

    logic        r1_valid;
    logic [19:0] r1_base;
    logic [15:0] r1_tab;
    logic [15:0] r1_truth;
    logic        r1_bad;
    logic        r1_last;

    logic        r2_valid;
    logic [35:0] r2_prod;
    logic        r2_bad;
    logic        r2_last;

    logic [31:0] r_sum, n_sum;
    logic        r_err, n_err;
    logic        r_out_valid, n_out_valid;
    t_out        r_out, n_out;

    logic [19:0] w_neglog;
    logic [21:0] w_term;
    logic [32:0] w_add;
    logic [31:0] w_sat;

    assign w_en    = !r_out_valid || !i_stall;
    assign o_pop   = w_en && !i_empty;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    assign w_neglog = r1_base - 20'(r1_tab);
    assign w_term   = 22'((r2_prod + 36'd16384) >> 15);
    assign w_add    = {1'b0, r_sum} + 33'(w_term);
    assign w_sat    = w_add[32] ? 32'hFFFF_FFFF : w_add[31:0];

    always_comb begin
        n_sum       = r_sum;
        n_err       = r_err;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        if (w_en) begin
            n_out_valid = 1'b0;
            if (r2_valid) begin
                if (r2_last) begin
                    n_out_valid          = 1'b1;
                    n_out.loss           = w_sat;
                    n_out.bad_prediction = r_err || r2_bad;
                    n_sum                = '0;
                    n_err                = 1'b0;
                end else begin
                    n_sum = w_sat;
                    n_err = r_err || r2_bad;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r_sum       <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en) begin
                r1_valid <= !i_empty;
                r2_valid <= r1_valid;
            end
            r_sum       <= n_sum;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_base  <= 20'(i_cls.shift) * 20'(LN2_Q16);
            r1_tab   <= w_rom[i_cls.idx[LOG_TABLE_BITS-1:0]];
            r1_truth <= i_cls.truth;
            r1_bad   <= i_cls.bad;
            r1_last  <= i_cls.last;
            r2_prod  <= 36'(r1_truth) * 36'(w_neglog);
            r2_bad   <= r1_bad;
            r2_last  <= r1_last;
        end
        r_out <= n_out;
    end

endmodule
`default_nettype wire

>>> sv/cross_entropy_loss_accumulate_top.sv
// cross-entropy loss accumulator top level
// input channel: i_valid/o_stall carry one element transaction (prediction and truth in
//   unsigned q1.15, last marks the end of a sample column)
// output channel: o_valid/i_stall carry one result transaction per column: the q16.16
//   loss sum, saturated at its maximum, and a flag for a zero prediction met by nonzero truth
// an element goes into a four-entry queue in the cycle it is taken; the back end then
//   runs a table lookup stage, a multiply stage and an accumulate stage
// a column's last element passes through the queue, the lookup register and the multiply
//   register before its result is registered onto o_valid and o_data
// throughput: one element per cycle while no waiting result is stalled, set by the accumulate stage
// when the receiver stalls a waiting result, the back end holds, the queue fills and
//   o_stall rises once four elements are queued
// reset clears the queue, the pipeline valids, the running sum and the error flag; the
//   table is constant logic and needs no fill
`default_nettype none
module cross_entropy_loss_accumulate_top #(
    parameter int LOG_TABLE_BITS = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire cela_pkg::t_in   i_data,
    output logic                 o_stall,
    output logic                 o_valid,
    output cela_pkg::t_out       o_data,
    input  wire logic            i_stall
);
    import cela_pkg::*;

    t_cls w_front_cls;
    t_cls w_queue_cls;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    cela_front #(
        .LOG_TABLE_BITS(LOG_TABLE_BITS)
    ) u_front (
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_full  (w_full),
        .o_stall (o_stall),
        .o_push  (w_push),
        .o_cls   (w_front_cls)
    );

    cela_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cls   (w_front_cls),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_cls   (w_queue_cls)
    );

    cela_back #(
        .LOG_TABLE_BITS(LOG_TABLE_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_cls   (w_queue_cls),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

endmodule
`default_nettype wire
